// ===== hdl/sc1a_pkg.sv =====
// Package for the set-1 scan code translator: key kinds, modifier bit masks,
// and the 84-row key table as a constant function.
// No dependencies.
package sc1a_pkg;

    localparam int unsigned KEY_COUNT = 84;
    localparam int unsigned ROM_SIZE  = 84;

    localparam logic [7:0] KEY_LIMIT = (KEY_COUNT < ROM_SIZE) ? 8'(KEY_COUNT) : 8'(ROM_SIZE);

    localparam logic [4:0] MOD_RSHIFT = 5'b00001;
    localparam logic [4:0] MOD_LSHIFT = 5'b00010;
    localparam logic [4:0] MOD_CAPS   = 5'b00100;
    localparam logic [4:0] MOD_CTRL   = 5'b01000;
    localparam logic [4:0] MOD_ALT    = 5'b10000;

    typedef enum logic [2:0] {
        K_NORM,
        K_NONE,
        K_RSH,
        K_LSH,
        K_CTL,
        K_ALT,
        K_CAP
    } key_kind_t;

    typedef struct packed {
        logic [7:0] plain;
        logic [7:0] shifted;
        logic [7:0] ctrl;
        key_kind_t  kind;
    } rom_row_t;

    function automatic rom_row_t key_rom(input logic [6:0] key);
        rom_row_t row;
        case (key)
            7'd0:    row = '{8'h00, 8'h00, 8'h00, K_NORM};
            7'd1:    row = '{8'h1b, 8'h1b, 8'h1b, K_NONE};
            7'd2:    row = '{8'h31, 8'h21, 8'h00, K_NORM};
            7'd3:    row = '{8'h32, 8'h40, 8'h00, K_NORM};
            7'd4:    row = '{8'h33, 8'h23, 8'h00, K_NORM};
            7'd5:    row = '{8'h34, 8'h24, 8'h00, K_NORM};
            7'd6:    row = '{8'h35, 8'h25, 8'h00, K_NORM};
            7'd7:    row = '{8'h36, 8'h5e, 8'h1e, K_NORM};
            7'd8:    row = '{8'h37, 8'h26, 8'h00, K_NORM};
            7'd9:    row = '{8'h38, 8'h2a, 8'h00, K_NORM};
            7'd10:   row = '{8'h39, 8'h28, 8'h00, K_NORM};
            7'd11:   row = '{8'h30, 8'h29, 8'h00, K_NORM};
            7'd12:   row = '{8'h2d, 8'h5f, 8'h1f, K_NORM};
            7'd13:   row = '{8'h3d, 8'h2b, 8'h00, K_NORM};
            7'd14:   row = '{8'h08, 8'h08, 8'h7f, K_NORM};
            7'd15:   row = '{8'h09, 8'h00, 8'h00, K_NORM};
            7'd16:   row = '{8'h71, 8'h51, 8'h11, K_NORM};
            7'd17:   row = '{8'h77, 8'h57, 8'h17, K_NORM};
            7'd18:   row = '{8'h65, 8'h45, 8'h05, K_NORM};
            7'd19:   row = '{8'h72, 8'h52, 8'h12, K_NORM};
            7'd20:   row = '{8'h74, 8'h54, 8'h14, K_NORM};
            7'd21:   row = '{8'h79, 8'h59, 8'h19, K_NORM};
            7'd22:   row = '{8'h75, 8'h55, 8'h15, K_NORM};
            7'd23:   row = '{8'h69, 8'h49, 8'h09, K_NORM};
            7'd24:   row = '{8'h6f, 8'h4f, 8'h0f, K_NORM};
            7'd25:   row = '{8'h70, 8'h50, 8'h10, K_NORM};
            7'd26:   row = '{8'h5b, 8'h7b, 8'h1b, K_NORM};
            7'd27:   row = '{8'h5d, 8'h7d, 8'h1d, K_NORM};
            7'd28:   row = '{8'h0d, 8'h0d, 8'h0a, K_NORM};
            7'd29:   row = '{8'h00, 8'h00, 8'h00, K_CTL};
            7'd30:   row = '{8'h61, 8'h41, 8'h01, K_NORM};
            7'd31:   row = '{8'h73, 8'h53, 8'h13, K_NORM};
            7'd32:   row = '{8'h64, 8'h44, 8'h04, K_NORM};
            7'd33:   row = '{8'h66, 8'h46, 8'h06, K_NORM};
            7'd34:   row = '{8'h67, 8'h47, 8'h07, K_NORM};
            7'd35:   row = '{8'h68, 8'h48, 8'h08, K_NORM};
            7'd36:   row = '{8'h6a, 8'h4a, 8'h0a, K_NORM};
            7'd37:   row = '{8'h6b, 8'h4b, 8'h0b, K_NORM};
            7'd38:   row = '{8'h6c, 8'h4c, 8'h0c, K_NORM};
            7'd39:   row = '{8'h3b, 8'h3a, 8'h00, K_NORM};
            7'd40:   row = '{8'h27, 8'h22, 8'h00, K_NORM};
            7'd41:   row = '{8'h60, 8'h7e, 8'h00, K_NORM};
            7'd42:   row = '{8'h00, 8'h00, 8'h00, K_LSH};
            7'd43:   row = '{8'h5c, 8'h7c, 8'h00, K_NORM};
            7'd44:   row = '{8'h7a, 8'h5a, 8'h1a, K_NORM};
            7'd45:   row = '{8'h78, 8'h58, 8'h18, K_NORM};
            7'd46:   row = '{8'h63, 8'h43, 8'h03, K_NORM};
            7'd47:   row = '{8'h76, 8'h56, 8'h16, K_NORM};
            7'd48:   row = '{8'h62, 8'h42, 8'h02, K_NORM};
            7'd49:   row = '{8'h6e, 8'h4e, 8'h0e, K_NORM};
            7'd50:   row = '{8'h6d, 8'h4d, 8'h0d, K_NORM};
            7'd51:   row = '{8'h2c, 8'h3c, 8'h00, K_NORM};
            7'd52:   row = '{8'h2e, 8'h2e, 8'h00, K_NORM};
            7'd53:   row = '{8'h2f, 8'h3f, 8'h00, K_NORM};
            7'd54:   row = '{8'h00, 8'h00, 8'h00, K_RSH};
            7'd55:   row = '{8'h2a, 8'h2a, 8'h00, K_NORM};
            7'd56:   row = '{8'h00, 8'h00, 8'h00, K_ALT};
            7'd57:   row = '{8'h20, 8'h20, 8'h02, K_NORM};
            7'd58:   row = '{8'h00, 8'h00, 8'h00, K_CAP};
            7'd69:   row = '{8'h00, 8'h00, 8'h00, K_NONE};
            7'd70:   row = '{8'h00, 8'h00, 8'h00, K_NONE};
            7'd71:   row = '{8'h00, 8'h37, 8'h00, K_NORM};
            7'd72:   row = '{8'h00, 8'h38, 8'h00, K_NORM};
            7'd73:   row = '{8'h00, 8'h39, 8'h00, K_NORM};
            7'd74:   row = '{8'h2d, 8'h2d, 8'h00, K_NORM};
            7'd75:   row = '{8'h00, 8'h34, 8'h00, K_NORM};
            7'd76:   row = '{8'h00, 8'h35, 8'h00, K_NORM};
            7'd77:   row = '{8'h00, 8'h36, 8'h00, K_NORM};
            7'd78:   row = '{8'h2b, 8'h2b, 8'h00, K_NORM};
            7'd79:   row = '{8'h00, 8'h31, 8'h00, K_NORM};
            7'd80:   row = '{8'h00, 8'h32, 8'h00, K_NORM};
            7'd81:   row = '{8'h00, 8'h33, 8'h00, K_NORM};
            7'd82:   row = '{8'h00, 8'h30, 8'h00, K_NORM};
            7'd83:   row = '{8'h00, 8'h2e, 8'h00, K_NORM};
            default: row = '{8'h00, 8'h00, 8'h00, K_NORM};
        endcase
        return row;
    endfunction

endpackage

// ===== hdl/scancode_set1_to_ascii.sv =====
// Set-1 scan code to ASCII translator, top level.
// Depends on sc1a_pkg for the key table, key kinds and modifier masks.
//
//  channel | handshake            | payload
//  --------+----------------------+------------------------------------
//  in      | in_valid / in_stall  | scan_byte[7:0]
//  out     | out_valid / out_stall| ascii_char[7:0], key_code[6:0],
//          |                      | modifier_bits[4:0]
//
// One beat is taken per cycle while in_stall is low. A beat is held in the input
// register, where the table lookup and the modifier update happen, then its result
// lands in the output register and raises out_valid.
// Beats that give no result retire from the input register without waiting.
// Reset clears the modifier register and both valid flags.
// in_stall rises only when a result is held in the input register while a
// stalled result still occupies the output register.
module scancode_set1_to_ascii (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    input  logic [7:0] scan_byte,
    output logic       out_valid,
    input  logic       out_stall,
    output logic [7:0] ascii_char,
    output logic [6:0] key_code,
    output logic [4:0] modifier_bits
);

    logic                in_valid_reg;
    logic [7:0]          byte_reg;
    logic [4:0]          mod_reg;
    logic [4:0]          mod_next;
    logic                out_valid_reg;
    logic [7:0]          char_reg;
    logic [6:0]          code_reg;
    logic [4:0]          bits_reg;
    logic                release_key;
    logic [6:0]          key;
    logic                in_range;
    sc1a_pkg::rom_row_t  row;
    logic                emit;
    logic [7:0]          char_next;
    logic                advance;
    logic                out_free;
    logic [4:0]          held;

    assign release_key = byte_reg[7];
    assign key         = byte_reg[6:0];
    assign in_range    = ({1'b0, key} < sc1a_pkg::KEY_LIMIT);
    assign row         = sc1a_pkg::key_rom(key);

    always_comb
    begin
        mod_next = mod_reg;
        emit     = 1'b0;
        held     = 5'b00000;
        if (in_range)
        begin
            case (row.kind)
                sc1a_pkg::K_RSH: held = sc1a_pkg::MOD_RSHIFT;
                sc1a_pkg::K_LSH: held = sc1a_pkg::MOD_LSHIFT;
                sc1a_pkg::K_CTL: held = sc1a_pkg::MOD_CTRL;
                sc1a_pkg::K_ALT: held = sc1a_pkg::MOD_ALT;
                sc1a_pkg::K_CAP:
                begin
                    if (!release_key)
                    begin
                        mod_next = mod_reg ^ sc1a_pkg::MOD_CAPS;
                    end
                end
                sc1a_pkg::K_NORM: emit = !release_key;
                default: held = 5'b00000;
            endcase
            if (held != 5'b00000)
            begin
                mod_next = release_key ? (mod_reg & ~held) : (mod_reg | held);
            end
        end
    end

    always_comb
    begin
        if (mod_reg == sc1a_pkg::MOD_RSHIFT || mod_reg == sc1a_pkg::MOD_LSHIFT
            || mod_reg == sc1a_pkg::MOD_CAPS)
        begin
            char_next = row.shifted;
        end
        else if (mod_reg == sc1a_pkg::MOD_CTRL)
        begin
            char_next = row.ctrl;
        end
        else if (mod_reg == 5'b00000)
        begin
            char_next = row.plain;
        end
        else
        begin
            char_next = 8'h00;
        end
    end

    assign out_free = !out_valid_reg || !out_stall;
    assign advance  = in_valid_reg && (!emit || out_free);
    assign in_stall = in_valid_reg && !advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            mod_reg       <= 5'b00000;
        end
        else
        begin
            if (!in_stall)
            begin
                in_valid_reg <= in_valid;
            end
            if (advance)
            begin
                mod_reg <= mod_next;
            end
            if (out_free)
            begin
                out_valid_reg <= advance && emit;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (!in_stall && in_valid)
        begin
            byte_reg <= scan_byte;
        end
        if (out_free && advance && emit)
        begin
            char_reg <= char_next;
            code_reg <= key;
            bits_reg <= mod_reg;
        end
    end

    assign out_valid     = out_valid_reg;
    assign ascii_char    = char_reg;
    assign key_code      = code_reg;
    assign modifier_bits = bits_reg;

endmodule

// ===== sim/scan_xlate_checker.sv =====
`timescale 1ns / 1ps
// Scoreboard for the set-1 scan code translator: watches both channels, predicts
// each translated key press, and compares it with what the block delivers.
// Depends on sc1a_pkg for key kinds, modifier masks and KEY_COUNT.
module scan_xlate_checker (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    input  logic       in_stall,
    input  logic [7:0] scan_byte,
    input  logic       out_valid,
    input  logic       out_stall,
    input  logic [7:0] ascii_char,
    input  logic [6:0] key_code,
    input  logic [4:0] modifier_bits,
    output int         mismatch_count,
    output int         results_pending
);
    import sc1a_pkg::*;

    localparam logic [4:0] NO_MODS = 5'b00000;
    localparam int         REPORT_LIMIT = 10;

    typedef struct packed {
        logic [7:0] ch;
        logic [6:0] key;
        logic [4:0] mods;
    } key_event_t;

    // Per key: {plain, shifted, control} characters.
    localparam logic [23:0] CHAR_COLUMNS [0:83] = '{
        24'h000000, 24'h1b1b1b, 24'h312100, 24'h324000, 24'h332300, 24'h342400,
        24'h352500, 24'h365e1e, 24'h372600, 24'h382a00, 24'h392800, 24'h302900,
        24'h2d5f1f, 24'h3d2b00, 24'h08087f, 24'h090000, 24'h715111, 24'h775717,
        24'h654505, 24'h725212, 24'h745414, 24'h795919, 24'h755515, 24'h694909,
        24'h6f4f0f, 24'h705010, 24'h5b7b1b, 24'h5d7d1d, 24'h0d0d0a, 24'h000000,
        24'h614101, 24'h735313, 24'h644404, 24'h664606, 24'h674707, 24'h684808,
        24'h6a4a0a, 24'h6b4b0b, 24'h6c4c0c, 24'h3b3a00, 24'h272200, 24'h607e00,
        24'h000000, 24'h5c7c00, 24'h7a5a1a, 24'h785818, 24'h634303, 24'h765616,
        24'h624202, 24'h6e4e0e, 24'h6d4d0d, 24'h2c3c00, 24'h2e2e00, 24'h2f3f00,
        24'h000000, 24'h2a2a00, 24'h000000, 24'h202002, 24'h000000, 24'h000000,
        24'h000000, 24'h000000, 24'h000000, 24'h000000, 24'h000000, 24'h000000,
        24'h000000, 24'h000000, 24'h000000, 24'h000000, 24'h000000, 24'h003700,
        24'h003800, 24'h003900, 24'h2d2d00, 24'h003400, 24'h003500, 24'h003600,
        24'h2b2b00, 24'h003100, 24'h003200, 24'h003300, 24'h003000, 24'h002e00
    };

    key_kind_t  key_kinds [0:83];
    key_event_t expected_events [$];
    logic [4:0] held_mods;

    initial
    begin
        foreach (key_kinds[k])
        begin
            key_kinds[k] = K_NORM;
        end
        key_kinds[1]  = K_NONE;
        key_kinds[29] = K_CTL;
        key_kinds[42] = K_LSH;
        key_kinds[54] = K_RSH;
        key_kinds[56] = K_ALT;
        key_kinds[58] = K_CAP;
        key_kinds[69] = K_NONE;
        key_kinds[70] = K_NONE;
    end

    always @(posedge clk or negedge rst_n)
    begin
        logic [23:0] cols;
        logic [7:0]  want_char;
        logic [6:0]  key;
        logic        is_break;
        key_event_t  want;
        if (!rst_n)
        begin
            held_mods = NO_MODS;
            expected_events.delete();
            mismatch_count = 0;
            results_pending <= 0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                if (expected_events.size() == 0)
                begin
                    mismatch_count++;
                    if (mismatch_count <= REPORT_LIMIT)
                    begin
                        $display("unexpected beat: char %h key %0d mods %b",
                                 ascii_char, key_code, modifier_bits);
                    end
                end
                else
                begin
                    want = expected_events.pop_front();
                    if (ascii_char !== want.ch || key_code !== want.key
                        || modifier_bits !== want.mods)
                    begin
                        mismatch_count++;
                        if (mismatch_count <= REPORT_LIMIT)
                        begin
                            $display("mismatch: expected char %h key %0d mods %b, got char %h key %0d mods %b",
                                     want.ch, want.key, want.mods,
                                     ascii_char, key_code, modifier_bits);
                        end
                    end
                end
            end

            if (in_valid && !in_stall)
            begin
                is_break = scan_byte[7];
                key = scan_byte[6:0];
                if (key < KEY_COUNT)
                begin
                    case (key_kinds[key])
                        K_RSH: held_mods = is_break ? held_mods & ~MOD_RSHIFT
                                                    : held_mods | MOD_RSHIFT;
                        K_LSH: held_mods = is_break ? held_mods & ~MOD_LSHIFT
                                                    : held_mods | MOD_LSHIFT;
                        K_CTL: held_mods = is_break ? held_mods & ~MOD_CTRL
                                                    : held_mods | MOD_CTRL;
                        K_ALT: held_mods = is_break ? held_mods & ~MOD_ALT
                                                    : held_mods | MOD_ALT;
                        K_CAP:
                        begin
                            if (!is_break)
                            begin
                                held_mods = held_mods ^ MOD_CAPS;
                            end
                        end
                        K_NORM:
                        begin
                            if (!is_break)
                            begin
                                cols = CHAR_COLUMNS[key];
                                case (held_mods)
                                    MOD_RSHIFT, MOD_LSHIFT, MOD_CAPS: want_char = cols[15:8];
                                    MOD_CTRL: want_char = cols[7:0];
                                    NO_MODS:  want_char = cols[23:16];
                                    default:  want_char = 8'h00;
                                endcase
                                expected_events.push_back('{want_char, key, held_mods});
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            results_pending <= expected_events.size();
        end
    end

endmodule

// ===== sim/testbench.sv =====
`timescale 1ns / 1ps
// Top of the translator testbench: clock, reset, scan byte stimulus and output
// stall pattern around the block and its scoreboard, plus the final verdict.
// Depends on sc1a_pkg, scancode_set1_to_ascii and scan_xlate_checker.
module testbench;
    import sc1a_pkg::*;

    localparam logic [7:0] BREAK_BIT   = 8'h80;
    localparam logic [7:0] KEY_ZERO    = 8'h00;
    localparam logic [7:0] KEY_ESC     = 8'h01;
    localparam logic [7:0] KEY_Q       = 8'h10;
    localparam logic [7:0] KEY_A       = 8'h1e;
    localparam logic [7:0] KEY_CTRL    = 8'h1d;
    localparam logic [7:0] KEY_LSHIFT  = 8'h2a;
    localparam logic [7:0] KEY_RSHIFT  = 8'h36;
    localparam logic [7:0] KEY_ALT     = 8'h38;
    localparam logic [7:0] KEY_CAPS    = 8'h3a;
    localparam logic [7:0] KEY_NUMLOCK = 8'h45;
    localparam logic [7:0] KEY_SCROLL  = 8'h46;
    localparam logic [7:0] KEY_LAST    = 8'(KEY_COUNT - 1);
    localparam logic [7:0] KEY_BEYOND  = 8'(KEY_COUNT);
    localparam logic [7:0] BYTE_MAX    = 8'hff;

    localparam int ITEM_TARGET  = 1125;
    localparam int HOLD_CYCLES  = 300;
    localparam int DRAIN_CYCLES = 20;

    localparam logic [7:0] MODIFIER_KEYS [5] = '{
        KEY_RSHIFT, KEY_LSHIFT, KEY_CAPS, KEY_CTRL, KEY_ALT
    };

    localparam logic [7:0] OPENING_SEQ [25] = '{
        KEY_ZERO, KEY_Q, KEY_ZERO | BREAK_BIT,
        KEY_LSHIFT, KEY_Q, KEY_LSHIFT | BREAK_BIT,
        KEY_RSHIFT, KEY_A, KEY_RSHIFT | BREAK_BIT,
        KEY_CAPS, KEY_CAPS | BREAK_BIT, KEY_Q, KEY_CAPS,
        KEY_CTRL, KEY_Q, KEY_ALT, KEY_Q, KEY_ALT | BREAK_BIT, KEY_CTRL | BREAK_BIT,
        KEY_ESC, KEY_NUMLOCK, KEY_SCROLL, KEY_BEYOND, BYTE_MAX, KEY_LAST
    };

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       in_valid = 1'b0;
    logic [7:0] scan_byte = 8'h00;
    logic       out_stall = 1'b0;
    logic       in_stall;
    logic       out_valid;
    logic [7:0] ascii_char;
    logic [6:0] key_code;
    logic [4:0] modifier_bits;

    int   mismatches;
    int   awaiting;
    int   counted = 0;
    logic send_gaps = 1'b1;
    logic stall_gaps = 1'b1;
    logic hold_request = 1'b0;

    scancode_set1_to_ascii dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .scan_byte    (scan_byte),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .ascii_char   (ascii_char),
        .key_code     (key_code),
        .modifier_bits(modifier_bits)
    );

    scan_xlate_checker xlate_check (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .scan_byte      (scan_byte),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .ascii_char     (ascii_char),
        .key_code       (key_code),
        .modifier_bits  (modifier_bits),
        .mismatch_count (mismatches),
        .results_pending(awaiting)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    task automatic send_scan(input logic [7:0] b);
        if (b[6:0] < KEY_COUNT)
        begin
            counted++;
        end
        while (send_gaps && $urandom_range(99) < 36)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        scan_byte <= b;
        @(posedge clk);
        while (in_stall)
        begin
            @(posedge clk);
        end
    endtask

    // Output side: random stalls, and one long hold-off on request.
    initial
    begin
        forever
        begin
            @(posedge clk);
            if (hold_request)
            begin
                out_stall <= 1'b1;
                hold_request <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
            end
            out_stall <= stall_gaps && ($urandom_range(99) < 36);
        end
    end

    initial
    begin
        #2_000_000;
        $display("DONE: errors detected");
        $finish;
    end

    initial
    begin
        logic [7:0] chord_mods [$];
        logic [7:0] typed;
        int         pick;
        bit         hold_done;
        bit         drain_done;
        hold_done = 1'b0;
        drain_done = 1'b0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (OPENING_SEQ[i])
        begin
            send_scan(OPENING_SEQ[i]);
        end

        while (counted < ITEM_TARGET)
        begin
            if (!hold_done && counted >= 300)
            begin
                hold_request <= 1'b1;
                hold_done = 1'b1;
            end
            send_gaps = !(counted >= 400 && counted < 650);
            stall_gaps = send_gaps;
            if (!drain_done && counted >= 800)
            begin
                in_valid <= 1'b0;
                @(posedge clk);
                wait (awaiting == 0);
                drain_done = 1'b1;
            end

            if ($urandom_range(99) < 75)
            begin
                if ($urandom_range(99) < 15)
                begin
                    foreach (MODIFIER_KEYS[m])
                    begin
                        if (MODIFIER_KEYS[m] != KEY_CAPS)
                        begin
                            send_scan(MODIFIER_KEYS[m] | BREAK_BIT);
                        end
                    end
                end
                chord_mods.delete();
                pick = $urandom_range(9);
                if (pick >= 5)
                begin
                    chord_mods.push_back(MODIFIER_KEYS[$urandom_range(4)]);
                end
                if (pick == 9)
                begin
                    chord_mods.push_back(MODIFIER_KEYS[$urandom_range(4)]);
                end
                foreach (chord_mods[m])
                begin
                    send_scan(chord_mods[m]);
                end
                repeat ($urandom_range(1, 6))
                begin
                    typed = 8'($urandom_range(0, KEY_COUNT - 1));
                    send_scan(typed);
                    if ($urandom_range(1) == 1)
                    begin
                        send_scan(typed | BREAK_BIT);
                    end
                end
                foreach (chord_mods[m])
                begin
                    send_scan(chord_mods[m] | BREAK_BIT);
                    if (chord_mods[m] == KEY_CAPS && $urandom_range(9) != 0)
                    begin
                        send_scan(KEY_CAPS);
                        send_scan(KEY_CAPS | BREAK_BIT);
                    end
                end
            end
            else
            begin
                repeat ($urandom_range(1, 4))
                begin
                    send_scan(8'($urandom_range(0, 255)));
                end
            end
        end

        in_valid <= 1'b0;
        @(posedge clk);
        wait (awaiting == 0);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatches == 0)
        begin
            $display("DONE: 0 errors");
        end
        else
        begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
